// ----- rtl/core/tccs_pkg.sv -----
`timescale 1ns / 1ps
// Package for the text console: grid geometry, character codes and the
// packed word types of the command and result ports. No dependencies.
package tccs_pkg;

    // Grid geometry
    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 8;
    localparam int CELLS    = ROWS * COLUMNS;

    // Internal widths follow the geometry
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int TAB_W  = $clog2(COLUMNS + TAB_STOP);
    localparam int ADDR_W = $clog2(CELLS);

    // Port field widths
    localparam int ROW_FW = 5;
    localparam int COL_FW = 7;

    // Character codes
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;

    // Command modes
    localparam logic MODE_PUT  = 1'b0;
    localparam logic MODE_READ = 1'b1;

    localparam logic [7:0] COLOR_RESET = 8'd15;

    typedef struct packed {
        logic              mode;
        logic [7:0]        char_code;
        logic [ROW_FW-1:0] read_row;
        logic [COL_FW-1:0] read_col;
    } t_cmd;

    typedef struct packed {
        logic [7:0]        cell_char;
        logic [7:0]        cell_color;
        logic [ROW_FW-1:0] cursor_row;
        logic [COL_FW-1:0] cursor_col;
        logic              scrolled;
    } t_result;

endpackage

// ----- rtl/core/text_console_cursor_scroll.sv -----
`timescale 1ns / 1ps
// Text console top level: cell memory, cursor and scroll sequencer.
// Depends on tccs_pkg.
//
// A command word is taken when start is high and busy is low; every command
// gives one result word, shown for one cycle with o_done, which the receiver
// cannot stall. A put of a character, newline or tab that does not scroll
// answers in the cycle after it is taken; a read of a cell answers after the
// single-port cell memory's registered read and the S_READ state. A put that
// moves past the last row scrolls: the grid is not copied, a row offset turns
// instead, and the freed bottom row is cleared one cell a cycle, so the result
// comes as that sweep ends. After reset the block sweeps all ROWS * COLUMNS
// cells to zero with busy high; text color writes are taken at any time.
module text_console_cursor_scroll (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  tccs_pkg::t_cmd   i_item,
    output logic             busy,
    output logic             o_done,
    output tccs_pkg::t_result o_result,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_data
);
    import tccs_pkg::*;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CLEAR
    } t_state;

    t_state            r_state;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_base;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [COL_W-1:0]  r_clr_cnt;
    logic              r_rd_ok;
    logic [7:0]        r_color;
    logic              r_done;
    t_result           r_result;

    logic [15:0]       mem [CELLS];
    logic [15:0]       r_rdata;

    logic              accept;
    logic [ROW_W-1:0]  n_row;
    logic [COL_W-1:0]  n_col;
    logic              n_scroll;
    logic              n_write;
    logic [TAB_W-1:0]  tab_col;
    logic              rd_ok;
    logic [ROW_W-1:0]  acc_row;
    logic [COL_W-1:0]  acc_col;
    logic [ROW_W:0]    phys_sum;
    logic [ROW_W-1:0]  phys_row;
    logic [ADDR_W-1:0] cell_addr;
    logic [ROW_W:0]    base_sum;
    logic [ROW_W-1:0]  n_base;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [15:0]       mem_wdata;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    // Hold the text color
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= COLOR_RESET;
        end else if (i_cfg_we) begin
            r_color <= i_cfg_data;
        end
    end

    // Work out the cursor after a put
    always_comb begin
        n_row    = r_row;
        n_col    = r_col;
        n_scroll = 1'b0;
        n_write  = 1'b0;
        tab_col  = TAB_W'(r_col) + TAB_W'(TAB_STOP);
        case (i_item.char_code)
            CH_NEWLINE: begin
                n_col    = '0;
                n_scroll = 1'b1;
            end
            CH_TAB: begin
                if (tab_col >= TAB_W'(COLUMNS)) begin
                    n_col    = COL_W'(tab_col - TAB_W'(COLUMNS));
                    n_scroll = 1'b1;
                end else begin
                    n_col = COL_W'(tab_col);
                end
            end
            default: begin
                n_write = 1'b1;
                if (TAB_W'(r_col) + TAB_W'(1) >= TAB_W'(COLUMNS)) begin
                    n_col    = '0;
                    n_scroll = 1'b1;
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end
        endcase
        // n_scroll flags a row advance here; it turns into a scroll on the last row
        if (n_scroll) begin
            if (32'(r_row) + 1 < ROWS) begin
                n_row    = r_row + ROW_W'(1);
                n_scroll = 1'b0;
            end else begin
                n_row = ROW_W'(ROWS - 1);
            end
        end
    end

    // Map the logical row through the scroll offset to a cell address
    always_comb begin
        rd_ok   = (32'(i_item.read_row) < ROWS) && (32'(i_item.read_col) < COLUMNS);
        acc_row = (i_item.mode == MODE_READ) ? ROW_W'(i_item.read_row) : r_row;
        acc_col = (i_item.mode == MODE_READ) ? COL_W'(i_item.read_col) : r_col;
        phys_sum = (ROW_W + 1)'(acc_row) + (ROW_W + 1)'(r_base);
        if (phys_sum >= (ROW_W + 1)'(ROWS)) begin
            phys_row = ROW_W'(phys_sum - (ROW_W + 1)'(ROWS));
        end else begin
            phys_row = ROW_W'(phys_sum);
        end
        cell_addr = ADDR_W'(phys_row) * ADDR_W'(COLUMNS) + ADDR_W'(acc_col);
        base_sum  = (ROW_W + 1)'(r_base) + (ROW_W + 1)'(1);
        n_base    = (base_sum >= (ROW_W + 1)'(ROWS)) ? '0 : ROW_W'(base_sum);
    end

    // Drive the single memory port
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = cell_addr;
        mem_wdata = {r_color, i_item.char_code};
        if (r_state == S_INIT || r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_addr  = r_clr_addr;
            mem_wdata = '0;
        end else if (accept && i_item.mode == MODE_PUT && n_write) begin
            mem_we = 1'b1;
        end
    end

    // Cell memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= mem[mem_addr];
    end

    // Sequence commands, clear sweeps and result words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_row      <= '0;
            r_col      <= '0;
            r_base     <= '0;
            r_clr_addr <= '0;
            r_clr_cnt  <= '0;
            r_rd_ok    <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_INIT: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (32'(r_clr_addr) == CELLS - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        if (i_item.mode == MODE_READ) begin
                            r_rd_ok <= rd_ok;
                            r_state <= S_READ;
                        end else begin
                            r_row <= n_row;
                            r_col <= n_col;
                            r_result.cell_char  <= '0;
                            r_result.cell_color <= '0;
                            r_result.cursor_row <= ROW_FW'(n_row);
                            r_result.cursor_col <= COL_FW'(n_col);
                            r_result.scrolled   <= n_scroll;
                            if (n_scroll) begin
                                // Turn the offset; the old top row becomes the new bottom
                                r_base     <= n_base;
                                r_clr_addr <= ADDR_W'(r_base) * ADDR_W'(COLUMNS);
                                r_clr_cnt  <= '0;
                                r_state    <= S_CLEAR;
                            end else begin
                                r_done <= 1'b1;
                            end
                        end
                    end
                end
                S_READ: begin
                    r_result.cell_char  <= r_rd_ok ? r_rdata[7:0]  : 8'd0;
                    r_result.cell_color <= r_rd_ok ? r_rdata[15:8] : 8'd0;
                    r_result.cursor_row <= ROW_FW'(r_row);
                    r_result.cursor_col <= COL_FW'(r_col);
                    r_result.scrolled   <= 1'b0;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    r_clr_cnt  <= r_clr_cnt + COL_W'(1);
                    if (32'(r_clr_cnt) == COLUMNS - 1) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/tccs_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the text console, bound to the top level.
// Depends on tccs_pkg and text_console_cursor_scroll.
module tccs_props (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input tccs_pkg::t_cmd    i_item,
    input logic              busy,
    input logic              o_done,
    input tccs_pkg::t_result o_result
);
    import tccs_pkg::*;

    // A read word raises busy once taken and then answers with o_done
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_item.mode == MODE_READ |=> busy ##1 o_done)
        else $error("read word did not answer in two cycles");

    // A scroll always leaves the cursor on the last row
    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.scrolled |-> o_result.cursor_row == ROW_FW'(ROWS - 1))
        else $error("scroll left cursor off the last row");

    // A scroll result comes only at the end of a clear sweep
    a_scroll_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.scrolled |-> $past(busy))
        else $error("scroll result without a clear sweep");

    // Reported cursor column stays within the row
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> 32'(o_result.cursor_col) < COLUMNS)
        else $error("cursor column out of range");

endmodule

bind text_console_cursor_scroll tccs_props u_tccs_props (.*);

// ----- tb/sv/tccs_checker.sv -----
`timescale 1ns / 1ps
// Checker for the text console: keeps a shadow grid, cursor and color,
// predicts one result word per command word and compares. Depends on tccs_pkg.
module tccs_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  tccs_pkg::t_cmd    i_cmd,
    input  logic              i_done,
    input  tccs_pkg::t_result i_result,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);
    import tccs_pkg::*;

    // Shadow copy of the console state
    logic [15:0] shadow_cells [CELLS];
    int unsigned shadow_row;
    int unsigned shadow_col;
    logic [7:0]  shadow_color;

    // Result words still owed by the block, oldest first
    t_result due_words [$];

    int fail_count = 0;
    int pending = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    // Move the shadow cursor down one row; scroll the grid at the bottom
    function automatic logic advance_row();
        if (shadow_row + 1 < ROWS) begin
            shadow_row++;
            return 1'b0;
        end
        for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
            shadow_cells[i] = shadow_cells[i + COLUMNS];
        end
        for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) begin
            shadow_cells[i] = '0;
        end
        shadow_row = ROWS - 1;
        return 1'b1;
    endfunction

    // Apply one command word to the shadow state and return the result word
    function automatic t_result predict_console_word(t_cmd cmd);
        t_result     word;
        int unsigned idx;
        int unsigned next_col;
        word = '0;
        if (cmd.mode == MODE_READ) begin
            // out-of-range reads return an empty cell
            if (cmd.read_row < ROWS && cmd.read_col < COLUMNS) begin
                idx = cmd.read_row * COLUMNS + cmd.read_col;
                word.cell_char  = shadow_cells[idx][7:0];
                word.cell_color = shadow_cells[idx][15:8];
            end
        end else if (cmd.char_code == CH_NEWLINE) begin
            shadow_col = 0;
            word.scrolled = advance_row();
        end else if (cmd.char_code == CH_TAB) begin
            // a tab past the row end carries its remainder onto the next row
            next_col = shadow_col + TAB_STOP;
            if (next_col >= COLUMNS) begin
                shadow_col = next_col - COLUMNS;
                word.scrolled = advance_row();
            end else begin
                shadow_col = next_col;
            end
        end else begin
            idx = shadow_row * COLUMNS + shadow_col;
            if (idx < CELLS) begin
                shadow_cells[idx] = {shadow_color, cmd.char_code};
            end
            shadow_col++;
            if (shadow_col >= COLUMNS) begin
                shadow_col = 0;
                word.scrolled = advance_row();
            end
        end
        word.cursor_row = ROW_FW'(shadow_row);
        word.cursor_col = COL_FW'(shadow_col);
        return word;
    endfunction

    task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    // Track config writes, check finished words, queue new predictions
    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++) begin
                shadow_cells[i] = '0;
            end
            shadow_row   = 0;
            shadow_col   = 0;
            shadow_color = COLOR_RESET;
            due_words.delete();
        end else begin
            if (i_cfg_we) begin
                shadow_color = i_cfg_data;
            end
            if (i_done) begin
                if (due_words.size() == 0) begin
                    $error("result word with none expected: %p", i_result);
                    fail_count++;
                end else begin
                    want = due_words.pop_front();
                    check_field("cell_char", 16'(want.cell_char),
                                16'(i_result.cell_char));
                    check_field("cell_color", 16'(want.cell_color),
                                16'(i_result.cell_color));
                    check_field("cursor_row", 16'(want.cursor_row),
                                16'(i_result.cursor_row));
                    check_field("cursor_col", 16'(want.cursor_col),
                                16'(i_result.cursor_col));
                    check_field("scrolled", 16'(want.scrolled),
                                16'(i_result.scrolled));
                end
            end
            if (i_start && !i_busy) begin
                due_words.push_back(predict_console_word(i_cmd));
            end
        end
        pending = due_words.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the text console: clock, reset, command and color
// stimulus, verdict. Depends on tccs_pkg, tccs_checker and the block itself.
module tb_top;
    import tccs_pkg::*;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       start      = 1'b0;
    t_cmd       i_item     = '0;
    logic       i_cfg_we   = 1'b0;
    logic [7:0] i_cfg_data = '0;
    logic       busy;
    logic       o_done;
    t_result    o_result;
    int         fail_count;
    int         pending;

    text_console_cursor_scroll u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_item     (i_item),
        .busy       (busy),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    tccs_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (i_item),
        .i_done       (o_done),
        .i_result     (o_result),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_cmd make_cmd(logic mode, logic [7:0] ch,
                                      logic [ROW_FW-1:0] row, logic [COL_FW-1:0] col);
        t_cmd c;
        c.mode      = mode;
        c.char_code = ch;
        c.read_row  = row;
        c.read_col  = col;
        return c;
    endfunction

    // Mostly puts of random character codes, some line moves, reads aimed at the grid and
    // a few reads anywhere in the field range
    function automatic t_cmd random_cmd();
        t_cmd        c;
        int unsigned pick;
        c = make_cmd(MODE_PUT, 8'($urandom_range(0, 255)),
                     ROW_FW'($urandom_range(0, 31)), COL_FW'($urandom_range(0, 127)));
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            c.char_code = CH_NEWLINE;
        end else if (pick < 20) begin
            c.char_code = CH_TAB;
        end else if (pick < 40) begin
            c.mode     = MODE_READ;
            c.read_row = ROW_FW'($urandom_range(0, ROWS - 1));
            c.read_col = COL_FW'($urandom_range(0, COLUMNS - 1));
        end else if (pick < 45) begin
            c.mode = MODE_READ;
        end
        return c;
    endfunction

    // Present one command word and hold it until busy is low
    task automatic send_cmd(t_cmd c);
        start  <= 1'b1;
        i_item <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Write the text color once every owed result word is back
    task automatic set_text_color(logic [7:0] color);
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= color;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Limit on the whole run
    initial begin
        #4_000_000;
        $display("[text_console_cursor_scroll] ERROR");
        $finish;
    end

    initial begin : stimulus
        t_cmd       directed [$];
        logic [7:0] colors [8];
        int         stretch_left;
        logic       quiet;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: out-of-range reads, edge characters, tab landing on the row end
        directed.push_back(make_cmd(MODE_READ, 8'h00, 5'd31, 7'd127));
        directed.push_back(make_cmd(MODE_READ, 8'hFF, 5'd25, 7'd0));
        directed.push_back(make_cmd(MODE_READ, CH_TAB, 5'd0, 7'd80));
        directed.push_back(make_cmd(MODE_PUT, 8'h00, 5'd31, 7'd127));
        directed.push_back(make_cmd(MODE_PUT, 8'hFF, 5'd0, 7'd0));
        directed.push_back(make_cmd(MODE_PUT, 8'h41, 5'd0, 7'd0));
        directed.push_back(make_cmd(MODE_PUT, CH_NEWLINE, 5'd0, 7'd0));
        for (int i = 0; i < 10; i++) begin
            directed.push_back(make_cmd(MODE_PUT, CH_TAB, 5'd0, 7'd0));
        end
        directed.push_back(make_cmd(MODE_READ, 8'h00, 5'd0, 7'd0));
        directed.push_back(make_cmd(MODE_READ, CH_NEWLINE, 5'd0, 7'd1));
        directed.push_back(make_cmd(MODE_READ, 8'h00, 5'd0, 7'd2));
        directed.push_back(make_cmd(MODE_READ, 8'h00, 5'd24, 7'd79));
        foreach (directed[i]) begin
            send_cmd(directed[i]);
        end

        // Random phases under different colors; the last one runs without gaps
        colors = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h00, 8'h7F, 8'hFE, 8'h0F};
        for (int p = 0; p < 8; p++) begin
            set_text_color(p < 2 ? colors[p] : 8'($urandom_range(0, 255)));
            stretch_left = 0;
            quiet        = 1'b0;
            for (int n = 0; n < 250; n++) begin
                if (stretch_left == 0) begin
                    stretch_left = $urandom_range(10, 40);
                    quiet        = ($urandom_range(0, 2) == 0);
                end
                stretch_left--;
                if (p < 7 && !quiet && $urandom_range(0, 2) == 0) begin
                    idle_cycles($urandom_range(1, 6));
                end
                send_cmd(random_cmd());
            end
        end
        start <= 1'b0;

        // Drain owed words, then watch for stray results past the scroll latency
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[text_console_cursor_scroll] OK");
        end else begin
            $display("[text_console_cursor_scroll] ERROR");
        end
        $finish;
    end

endmodule
